// ===== src/tsdf_pkg.sv =====
`timescale 1ns / 1ps

package tsdf_pkg;

    // field widths
    localparam int TS_W     = 48;
    localparam int PART_W   = 14;

    // milliseconds per day = 2^10 * 84375
    localparam int MS_SHIFT   = 10;
    localparam int X_W        = TS_W - MS_SHIFT;
    localparam int DAY_MS_ODD = 84375;
    localparam int DAYS_W     = 22;

    // civil date conversion constants
    localparam int Z_W           = 23;
    localparam int EPOCH_OFS     = 719468;
    localparam int ERA_DAYS      = 146097;
    localparam int ERA_W         = 6;
    localparam int DOE_W         = 18;
    localparam int LEAP4_DAYS    = 1460;
    localparam int A_W           = 8;
    localparam int CENT_DAYS     = 36524;
    localparam int YOE_Q_W       = 10;
    localparam int YOE_W         = 9;
    localparam int YEAR_DAYS     = 365;
    localparam int YEARS_PER_ERA = 400;
    localparam int DOY_W         = 9;
    localparam int MP_NUM_W      = 11;
    localparam int MP_DIV        = 153;
    localparam int MP_W          = 4;
    localparam int DAY_W         = 5;
    localparam int MP_WRAP       = 10;

    localparam logic [TS_W-1:0] LAST_VALID_MS = 48'd253402300799999;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_SELECT    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_NULLABLE = 4'd1;

    // field_select codes
    localparam logic [1:0] SEL_DAY   = 2'd0;
    localparam logic [1:0] SEL_MONTH = 2'd1;
    localparam logic [1:0] SEL_YEAR  = 2'd2;

    typedef struct packed {
        logic [TS_W-1:0] timestamp_ms;
        logic            in_null;
    } in_item_t;

    typedef struct packed {
        logic [PART_W-1:0] date_part;
        logic              out_null;
        logic              out_of_range;
    } out_item_t;

    typedef struct packed {
        logic nul;
        logic oor;
    } flags_t;

    typedef struct packed {
        flags_t           flags;
        logic [ERA_W-1:0] era;
        logic [DOE_W-1:0] doe;
    } doe_side_t;

    typedef struct packed {
        flags_t            flags;
        logic [PART_W-1:0] year_base;
        logic [DOY_W-1:0]  doy;
    } mp_side_t;

    // first day of each shifted month (march based), counted from day zero of the year
    function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
        logic [DOY_W-1:0] ms;
        case (mp)
            4'd0:    ms = 9'd0;
            4'd1:    ms = 9'd31;
            4'd2:    ms = 9'd61;
            4'd3:    ms = 9'd92;
            4'd4:    ms = 9'd122;
            4'd5:    ms = 9'd153;
            4'd6:    ms = 9'd184;
            4'd7:    ms = 9'd214;
            4'd8:    ms = 9'd245;
            4'd9:    ms = 9'd275;
            4'd10:   ms = 9'd306;
            4'd11:   ms = 9'd337;
            default: ms = 9'd0;
        endcase
        return ms;
    endfunction

endpackage

// ===== src/tsdf_cdiv.sv =====
`timescale 1ns / 1ps

module tsdf_cdiv #(
    parameter int  NUM_W   = 38,
    parameter int  QUO_W   = 22,
    parameter int  DIVISOR = 84375,
    parameter int  BPS     = 2,
    parameter type side_t  = logic
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [NUM_W-1:0]              in_num,
    input  side_t                         in_side,
    output logic                          out_valid,
    output logic [QUO_W-1:0]              out_quo,
    output logic [$clog2(DIVISOR)-1:0]    out_rem,
    output side_t                         out_side
);

    localparam int REM_W  = $clog2(DIVISOR);
    localparam int W      = REM_W + QUO_W;
    localparam int STAGES = QUO_W / BPS;
    localparam logic [REM_W:0] DIV_C = (REM_W + 1)'(DIVISOR);

    // restoring division: upper part holds the remainder, lower part shifts
    // dividend bits out and quotient bits in
    function automatic logic [W-1:0] div_step(input logic [W-1:0] w);
        logic [REM_W:0] t;
        logic [REM_W:0] diff;
        logic           ge;
        t    = {w[W-1:QUO_W], w[QUO_W-1]};
        diff = t - DIV_C;
        ge   = (t >= DIV_C);
        return {(ge ? diff[REM_W-1:0] : t[REM_W-1:0]), w[QUO_W-2:0], ge};
    endfunction

    logic [W-1:0] word_reg  [STAGES];
    side_t        side_reg  [STAGES];
    logic         valid_reg [STAGES];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [W-1:0] w_in;
        logic [W-1:0] w_out;
        logic         v_in;
        side_t        sd_in;

        if (s == 0) begin : g_first
            assign w_in  = W'(in_num);
            assign v_in  = in_valid;
            assign sd_in = in_side;
        end else begin : g_next
            assign w_in  = word_reg[s-1];
            assign v_in  = valid_reg[s-1];
            assign sd_in = side_reg[s-1];
        end

        always_comb begin
            w_out = w_in;
            for (int b = 0; b < BPS; b++) begin
                w_out = div_step(w_out);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (adv) begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                word_reg[s] <= w_out;
                side_reg[s] <= sd_in;
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_quo   = word_reg[STAGES-1][QUO_W-1:0];
    assign out_rem   = word_reg[STAGES-1][W-1:QUO_W];
    assign out_side  = side_reg[STAGES-1];

endmodule

// ===== src/timestamp_date_field_extract.sv =====
`timescale 1ns / 1ps
// throughput: one item per cycle while the skid entry is empty; 29 register stages
// (five constant dividers at two quotient bits per stage, four glue stages) move on a
// common advance and feed the result register; a skid entry behind the result register
// takes one more item while a result waits; s_ready drops only while the skid entry is full
// reset: synchronous active-low aresetn clears valid bits, field_select and column_nullable
module timestamp_date_field_extract (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  tsdf_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output tsdf_pkg::out_item_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tsdf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tsdf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic       adv;
    logic [1:0] field_select_reg;
    logic       col_nullable_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_select_reg <= tsdf_pkg::SEL_DAY;
            col_nullable_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                tsdf_pkg::CFG_FIELD_SELECT:    field_select_reg <= cfg_data[1:0];
                tsdf_pkg::CFG_COLUMN_NULLABLE: col_nullable_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // stage 0: input register, special-case flags
    logic                          v0_reg;
    logic [tsdf_pkg::X_W-1:0]      x0_reg;
    tsdf_pkg::flags_t              flags0_reg;
    tsdf_pkg::flags_t              flags0_next;

    always_comb begin
        flags0_next.nul = col_nullable_reg && s_data.in_null;
        flags0_next.oor = !flags0_next.nul && (s_data.timestamp_ms > tsdf_pkg::LAST_VALID_MS);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x0_reg     <= s_data.timestamp_ms[tsdf_pkg::TS_W-1:tsdf_pkg::MS_SHIFT];
            flags0_reg <= flags0_next;
        end
    end

    // days since epoch
    logic                          d1_valid;
    logic [tsdf_pkg::DAYS_W-1:0]   d1_days;
    tsdf_pkg::flags_t              d1_flags;

    tsdf_cdiv #(
        .NUM_W   (tsdf_pkg::X_W),
        .QUO_W   (tsdf_pkg::DAYS_W),
        .DIVISOR (tsdf_pkg::DAY_MS_ODD),
        .BPS     (2),
        .side_t  (tsdf_pkg::flags_t)
    ) u_div_days (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (v0_reg),
        .in_num    (x0_reg),
        .in_side   (flags0_reg),
        .out_valid (d1_valid),
        .out_quo   (d1_days),
        .out_rem   (),
        .out_side  (d1_flags)
    );

    // stage: shift epoch to 0000-03-01
    logic                          v1_reg;
    logic [tsdf_pkg::Z_W-1:0]      z1_reg;
    tsdf_pkg::flags_t              flags1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= d1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            z1_reg     <= tsdf_pkg::Z_W'(d1_days) + tsdf_pkg::Z_W'(tsdf_pkg::EPOCH_OFS);
            flags1_reg <= d1_flags;
        end
    end

    // era and day of era
    logic                          d2_valid;
    logic [tsdf_pkg::ERA_W-1:0]    d2_era;
    logic [tsdf_pkg::DOE_W-1:0]    d2_doe;
    tsdf_pkg::flags_t              d2_flags;
    tsdf_pkg::doe_side_t           d2_side;

    tsdf_cdiv #(
        .NUM_W   (tsdf_pkg::Z_W),
        .QUO_W   (tsdf_pkg::ERA_W),
        .DIVISOR (tsdf_pkg::ERA_DAYS),
        .BPS     (2),
        .side_t  (tsdf_pkg::flags_t)
    ) u_div_era (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (v1_reg),
        .in_num    (z1_reg),
        .in_side   (flags1_reg),
        .out_valid (d2_valid),
        .out_quo   (d2_era),
        .out_rem   (d2_doe),
        .out_side  (d2_flags)
    );

    assign d2_side = '{flags: d2_flags, era: d2_era, doe: d2_doe};

    // four-year cycles within the era
    logic                          d3_valid;
    logic [tsdf_pkg::A_W-1:0]      d3_quad;
    tsdf_pkg::doe_side_t           d3_side;

    tsdf_cdiv #(
        .NUM_W   (tsdf_pkg::DOE_W),
        .QUO_W   (tsdf_pkg::A_W),
        .DIVISOR (tsdf_pkg::LEAP4_DAYS),
        .BPS     (2),
        .side_t  (tsdf_pkg::doe_side_t)
    ) u_div_quad (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (d2_valid),
        .in_num    (d2_doe),
        .in_side   (d2_side),
        .out_valid (d3_valid),
        .out_quo   (d3_quad),
        .out_rem   (),
        .out_side  (d3_side)
    );

    // stage: leap-corrected day count, century terms by compare
    logic                          v2_reg;
    logic [tsdf_pkg::DOE_W-1:0]    n2_reg;
    logic [tsdf_pkg::DOE_W-1:0]    n2_next;
    tsdf_pkg::doe_side_t           side2_reg;

    always_comb begin
        logic [2:0] cent;
        logic       last_day;
        cent = 3'(d3_side.doe >= tsdf_pkg::DOE_W'(tsdf_pkg::CENT_DAYS))
             + 3'(d3_side.doe >= tsdf_pkg::DOE_W'(2 * tsdf_pkg::CENT_DAYS))
             + 3'(d3_side.doe >= tsdf_pkg::DOE_W'(3 * tsdf_pkg::CENT_DAYS))
             + 3'(d3_side.doe >= tsdf_pkg::DOE_W'(4 * tsdf_pkg::CENT_DAYS));
        last_day = (d3_side.doe == tsdf_pkg::DOE_W'(tsdf_pkg::ERA_DAYS - 1));
        n2_next  = d3_side.doe - tsdf_pkg::DOE_W'(d3_quad) + tsdf_pkg::DOE_W'(cent)
                 - tsdf_pkg::DOE_W'(last_day);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= d3_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            n2_reg    <= n2_next;
            side2_reg <= d3_side;
        end
    end

    // year of era
    logic                          d4_valid;
    logic [tsdf_pkg::YOE_Q_W-1:0]  d4_yoe_q;
    tsdf_pkg::doe_side_t           d4_side;

    tsdf_cdiv #(
        .NUM_W   (tsdf_pkg::DOE_W),
        .QUO_W   (tsdf_pkg::YOE_Q_W),
        .DIVISOR (tsdf_pkg::YEAR_DAYS),
        .BPS     (2),
        .side_t  (tsdf_pkg::doe_side_t)
    ) u_div_year (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (v2_reg),
        .in_num    (n2_reg),
        .in_side   (side2_reg),
        .out_valid (d4_valid),
        .out_quo   (d4_yoe_q),
        .out_rem   (),
        .out_side  (d4_side)
    );

    // stage: day of year and base year
    logic                          v3_reg;
    tsdf_pkg::mp_side_t            side3_reg;
    tsdf_pkg::mp_side_t            side3_next;

    always_comb begin
        logic [tsdf_pkg::YOE_W-1:0] yoe;
        logic [1:0]                 cent;
        logic [tsdf_pkg::DOE_W-1:0] year_start;
        logic [tsdf_pkg::DOE_W-1:0] doy_full;
        yoe        = d4_yoe_q[tsdf_pkg::YOE_W-1:0];
        cent       = 2'(yoe >= tsdf_pkg::YOE_W'(100)) + 2'(yoe >= tsdf_pkg::YOE_W'(200))
                   + 2'(yoe >= tsdf_pkg::YOE_W'(300));
        year_start = tsdf_pkg::DOE_W'(tsdf_pkg::YEAR_DAYS) * tsdf_pkg::DOE_W'(yoe)
                   + tsdf_pkg::DOE_W'(yoe >> 2) - tsdf_pkg::DOE_W'(cent);
        doy_full   = d4_side.doe - year_start;
        side3_next.flags     = d4_side.flags;
        side3_next.doy       = doy_full[tsdf_pkg::DOY_W-1:0];
        side3_next.year_base = tsdf_pkg::PART_W'(d4_side.era)
                             * tsdf_pkg::PART_W'(tsdf_pkg::YEARS_PER_ERA)
                             + tsdf_pkg::PART_W'(yoe);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= d4_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side3_reg <= side3_next;
        end
    end

    // shifted month from (5 * doy + 2) / 153
    logic [tsdf_pkg::MP_NUM_W-1:0] mp_num;
    logic                          d5_valid;
    logic [tsdf_pkg::MP_W-1:0]     d5_mp;
    tsdf_pkg::mp_side_t            d5_side;

    assign mp_num = tsdf_pkg::MP_NUM_W'({side3_reg.doy, 2'b00})
                  + tsdf_pkg::MP_NUM_W'(side3_reg.doy) + tsdf_pkg::MP_NUM_W'(2);

    tsdf_cdiv #(
        .NUM_W   (tsdf_pkg::MP_NUM_W),
        .QUO_W   (tsdf_pkg::MP_W),
        .DIVISOR (tsdf_pkg::MP_DIV),
        .BPS     (2),
        .side_t  (tsdf_pkg::mp_side_t)
    ) u_div_month (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (v3_reg),
        .in_num    (mp_num),
        .in_side   (side3_reg),
        .out_valid (d5_valid),
        .out_quo   (d5_mp),
        .out_rem   (),
        .out_side  (d5_side)
    );

    // final: civil month, day, year and field selection
    tsdf_pkg::out_item_t fin_data;

    always_comb begin
        logic [tsdf_pkg::MP_W-1:0]   month;
        logic [tsdf_pkg::DOY_W-1:0]  day_full;
        logic [tsdf_pkg::PART_W-1:0] year;
        month    = (d5_mp < tsdf_pkg::MP_W'(tsdf_pkg::MP_WRAP)) ? d5_mp + tsdf_pkg::MP_W'(3)
                                                                : d5_mp - tsdf_pkg::MP_W'(9);
        day_full = d5_side.doy - tsdf_pkg::month_start(d5_mp) + tsdf_pkg::DOY_W'(1);
        // january and february belong to the next civil year
        year     = d5_side.year_base + tsdf_pkg::PART_W'(month <= tsdf_pkg::MP_W'(2));
        case (field_select_reg)
            tsdf_pkg::SEL_DAY:   fin_data.date_part = tsdf_pkg::PART_W'(day_full[tsdf_pkg::DAY_W-1:0]);
            tsdf_pkg::SEL_MONTH: fin_data.date_part = tsdf_pkg::PART_W'(month);
            tsdf_pkg::SEL_YEAR:  fin_data.date_part = year;
            default:             fin_data.date_part = '0;
        endcase
        fin_data.out_null     = d5_side.flags.nul;
        fin_data.out_of_range = d5_side.flags.oor;
        if (d5_side.flags.nul || d5_side.flags.oor) begin
            fin_data.date_part = '0;
        end
    end

    // result register with one skid entry
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                skid_valid_reg;
    logic                skid_valid_next;
    tsdf_pkg::out_item_t out_data_reg;
    tsdf_pkg::out_item_t out_data_next;
    tsdf_pkg::out_item_t skid_data_reg;
    tsdf_pkg::out_item_t skid_data_next;

    assign adv     = !skid_valid_reg;
    assign s_ready = adv;

    always_comb begin
        logic pop;
        logic push;
        pop             = out_valid_reg && m_ready;
        push            = adv && d5_valid;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_data_next  = fin_data;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = fin_data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`ifndef ASSERT_OFF
    // the skid entry is only used behind a full result register
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while result register empty");

    // a finished item arriving at a blocked result register lands in the skid entry
    a_skid_catch: assert property (@(posedge aclk) disable iff (!aresetn)
        (d5_valid && adv && out_valid_reg && !m_ready) |=> skid_valid_reg)
        else $error("finished item not caught by skid entry");

    // null and out-of-range results carry a zero value
    a_flag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (m_data.out_null || m_data.out_of_range))
            |-> (m_data.date_part == '0))
        else $error("flagged result with nonzero date part");

    // null takes priority over the range check
    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(m_data.out_null && m_data.out_of_range))
        else $error("null and out-of-range both set");
`endif

endmodule
